@@ sv/sfbm_pkg.sv @@
// Shared constants for the simplex fBm noise core.
// Used by sfbm_simplex, sfbm_norm and simplex_noise_fbm_core; depends on nothing.
`default_nettype none
package sfbm_pkg;
    localparam int FREQ_W      = 24;   // base frequency, unsigned Q0.24
    localparam int CNT_W       = 4;    // octave count register
    localparam int CFG_W       = 24;   // widest register
    localparam int COORD_W     = 32;   // point fields, signed Q16.16
    localparam int OUT_W       = 16;   // result, signed Q1.15
    localparam int P_W         = 56;   // point times frequency
    localparam int LAT_W       = 48;   // lattice arithmetic, modulo 2^48
    localparam int TERM_W      = 40;   // one octave term, Q.30
    localparam int ACC_W       = 44;   // octave sum
    localparam int DEF_MAX_OCT = 8;
    localparam int SIMPLEX_LAT = 10;   // register stages in one octave unit
    localparam int NORM_LAT    = 19;   // register stages in the normaliser

    localparam logic [14:0] F2Q      = 15'd23988;
    localparam logic [13:0] G2Q      = 14'd13849;
    localparam logic [31:0] HASH_MX  = 32'd374761393;
    localparam logic [31:0] HASH_MY  = 32'd668265263;
    localparam logic [31:0] HASH_MIX = 32'd1274126177;
    localparam logic [7:0]  KSCALE   = 8'd70;

    localparam logic CFG_BASE_FREQ = 1'b0;
    localparam logic CFG_OCT_COUNT = 1'b1;
endpackage
`default_nettype wire

@@ sv/simplex_noise_fbm_core.sv @@
// Fractal 2D simplex noise core: one point (x, z) per transaction in, one
// signed Q1.15 noise value out. The core takes a new point in every cycle
// unless the output stalls. Each point passes through one stage for the frequency
// multiply, ten in each octave unit (all octaves run side by side), one for the
// octave sum and nineteen in the bit-per-stage normalising divider.
// A stall at the output freezes the whole pipeline. Write registers only while idle.
`default_nettype none
module simplex_noise_fbm_core #(
    parameter int MAX_OCTAVES = sfbm_pkg::DEF_MAX_OCT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] point_x, [63:32] point_z
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] noise_value
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [sfbm_pkg::CFG_W-1:0] cfg_wdata
);
    localparam int LAT = 2 + sfbm_pkg::SIMPLEX_LAT + sfbm_pkg::NORM_LAT;
    localparam int KW  = sfbm_pkg::CNT_W;

    logic [sfbm_pkg::FREQ_W-1:0] freq_reg;
    logic [KW-1:0] cnt_reg, k;
    logic [LAT-1:0] vld_reg;
    logic ce;
    logic signed [sfbm_pkg::P_W-1:0] px_reg, pz_reg;
    logic signed [sfbm_pkg::TERM_W-1:0] term [MAX_OCTAVES];
    logic signed [sfbm_pkg::ACC_W-1:0] acc_next, acc_reg;
    logic signed [sfbm_pkg::OUT_W-1:0] result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg <= sfbm_pkg::FREQ_W'(65536);
            cnt_reg  <= KW'(4);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sfbm_pkg::CFG_BASE_FREQ: freq_reg <= cfg_wdata;
                default:                 cnt_reg  <= cfg_wdata[KW-1:0];
            endcase
        end
    end

    assign k  = (32'(cnt_reg) > MAX_OCTAVES) ? KW'(MAX_OCTAVES) : cnt_reg;
    assign ce = !vld_reg[LAT-1] || m_tready;
    assign s_tready = aresetn && ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            px_reg  <= sfbm_pkg::P_W'($signed(s_tdata[31:0]) * $signed({1'b0, freq_reg}));
            pz_reg  <= sfbm_pkg::P_W'($signed(s_tdata[63:32]) * $signed({1'b0, freq_reg}));
            acc_reg <= acc_next;
        end
    end

    for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_oct
        sfbm_simplex #(.OCT(o)) u_oct (
            .aclk(aclk), .en(ce), .px(px_reg), .pz(pz_reg), .term(term[o])
        );
    end

    always_comb begin
        acc_next = '0;
        for (int o = 0; o < MAX_OCTAVES; o++) begin
            if (o < 32'(k)) begin
                acc_next = acc_next + sfbm_pkg::ACC_W'(term[o]);
            end
        end
    end

    sfbm_norm u_norm (
        .aclk(aclk), .en(ce), .acc(acc_reg), .k(k), .result(result)
    );

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = result;

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !ce |=> $stable(vld_reg)) else $error("pipeline moved during a stall");
    a_zero_oct: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && cnt_reg == '0 && $stable(cnt_reg)) |-> m_tdata == '0)
        else $error("zero octaves gave a non-zero result");
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("output valid straight after reset");
endmodule
`default_nettype wire

@@ sv/sfbm_simplex.sv @@
// One octave of 2D simplex noise as a ten-stage pipeline.
// Uses constants from sfbm_pkg; instantiated once per octave by the top level.
`default_nettype none
module sfbm_simplex #(
    parameter int OCT = 0
) (
    input  wire logic                                   aclk,
    input  wire logic                                   en,
    input  wire logic signed [sfbm_pkg::P_W-1:0]        px,
    input  wire logic signed [sfbm_pkg::P_W-1:0]        pz,
    output logic signed [sfbm_pkg::TERM_W-1:0]          term
);
    localparam int LW = sfbm_pkg::LAT_W;
    localparam int TERM_W_L = sfbm_pkg::TERM_W;

    logic signed [sfbm_pkg::P_W-1:0] cx_full, cz_full;
    logic [LW-1:0] cx_reg, cz_reg, bx_reg, bz_reg;
    logic [63:0]   prod_reg;
    logic [31:0]   ha_reg, hb_reg;
    logic [15:0]   xf_reg, zf_reg;
    logic [14:0]   u_reg;
    logic          lower_reg;
    logic signed [17:0] x_reg [3], y_reg [3];
    logic signed [17:0] x2_reg [3], y2_reg [3];
    logic [31:0]   hm_reg [3], hx_reg [3];
    logic [34:0]   xx_reg [3], yy_reg [3];
    logic [29:0]   t30_reg [3], t2_reg [3];
    logic [25:0]   t4_reg [3];
    logic          pos_reg [3], pos2_reg [3], pos3_reg [3];
    logic signed [18:0] dot_reg [3], dot2_reg [3], dot3_reg [3];
    logic signed [45:0] c_reg [3];
    logic signed [TERM_W_L-1:0] term_reg;

    assign cx_full = px >>> (sfbm_pkg::FREQ_W - OCT);
    assign cz_full = pz >>> (sfbm_pkg::FREQ_W - OCT);

    always_ff @(posedge aclk) begin
        if (en) begin
            // Skew: only the low bits of the lattice position matter.
            cx_reg   <= cx_full[LW-1:0];
            cz_reg   <= cz_full[LW-1:0];
            prod_reg <= 64'(cx_full + cz_full) * 64'(sfbm_pkg::F2Q);
            bx_reg   <= cx_reg + prod_reg[63:16];
            bz_reg   <= cz_reg + prod_reg[63:16];
            ha_reg   <= bx_reg[LW-1:16] * sfbm_pkg::HASH_MX;
            hb_reg   <= bz_reg[LW-1:16] * sfbm_pkg::HASH_MY;
            xf_reg   <= bx_reg[15:0];
            zf_reg   <= bz_reg[15:0];
            u_reg    <= 15'((31'(bx_reg[15:0]) + 31'(bz_reg[15:0])) * 31'(sfbm_pkg::G2Q) >> 16);
            lower_reg <= bx_reg[15:0] > bz_reg[15:0];
        end
    end

    logic signed [17:0] x0, y0;
    logic [31:0] hsum [3];
    assign x0 = $signed({2'b00, xf_reg}) - $signed({3'b000, u_reg});
    assign y0 = $signed({2'b00, zf_reg}) - $signed({3'b000, u_reg});
    assign hsum[0] = ha_reg + hb_reg;
    assign hsum[1] = ha_reg + hb_reg + (lower_reg ? sfbm_pkg::HASH_MX : sfbm_pkg::HASH_MY);
    assign hsum[2] = ha_reg + hb_reg + sfbm_pkg::HASH_MX + sfbm_pkg::HASH_MY;

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= x0;
            y_reg[0] <= y0;
            x_reg[1] <= x0 + 18'sd13849 - (lower_reg ? 18'sd65536 : 18'sd0);
            y_reg[1] <= y0 + 18'sd13849 - (lower_reg ? 18'sd0 : 18'sd65536);
            x_reg[2] <= x0 - 18'sd65536 + 18'sd27698;
            y_reg[2] <= y0 - 18'sd65536 + 18'sd27698;
            for (int c = 0; c < 3; c++) begin
                hm_reg[c] <= hsum[c] ^ (hsum[c] >> 13);
            end
        end
    end

    logic signed [36:0] t [3];
    logic [2:0] gi [3];
    logic signed [18:0] dot [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            t[c]  = 37'sd2147483648 - $signed({2'b00, xx_reg[c]})
                    - $signed({2'b00, yy_reg[c]});
            gi[c] = hx_reg[c][2:0] ^ hx_reg[c][18:16];
            unique case (gi[c])
                3'd0: dot[c] = 19'(x2_reg[c]) + 19'(y2_reg[c]);
                3'd1: dot[c] = 19'(y2_reg[c]) - 19'(x2_reg[c]);
                3'd2: dot[c] = 19'(x2_reg[c]) - 19'(y2_reg[c]);
                3'd3: dot[c] = -19'(x2_reg[c]) - 19'(y2_reg[c]);
                3'd4: dot[c] = 19'(x2_reg[c]);
                3'd5: dot[c] = -19'(x2_reg[c]);
                3'd6: dot[c] = 19'(y2_reg[c]);
                default: dot[c] = -19'(y2_reg[c]);
            endcase
        end
    end

    logic signed [47:0] csum;
    logic signed [55:0] scaled;
    assign csum   = 48'(c_reg[0]) + 48'(c_reg[1]) + 48'(c_reg[2]);
    assign scaled = 56'(csum) * $signed({1'b0, sfbm_pkg::KSCALE});

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                hx_reg[c]  <= hm_reg[c] * sfbm_pkg::HASH_MIX;
                xx_reg[c]  <= 35'(x_reg[c] * x_reg[c]);
                yy_reg[c]  <= 35'(y_reg[c] * y_reg[c]);
                x2_reg[c]  <= x_reg[c];
                y2_reg[c]  <= y_reg[c];
                pos_reg[c] <= t[c] > 37'sd0;
                t30_reg[c] <= t[c][31:2];
                dot_reg[c] <= dot[c];
                t2_reg[c]  <= 30'((60'(t30_reg[c]) * 60'(t30_reg[c])) >> 30);
                pos2_reg[c] <= pos_reg[c];
                dot2_reg[c] <= dot_reg[c];
                t4_reg[c]  <= 26'((60'(t2_reg[c]) * 60'(t2_reg[c])) >> 30);
                pos3_reg[c] <= pos2_reg[c];
                dot3_reg[c] <= dot2_reg[c];
                c_reg[c]   <= pos3_reg[c] ? 46'($signed({1'b0, t4_reg[c]}) * dot3_reg[c])
                                          : 46'sd0;
            end
            term_reg <= TERM_W_L'((scaled >>> 16) >>> OCT);
        end
    end

    assign term = term_reg;
endmodule
`default_nettype wire

@@ sv/sfbm_norm.sv @@
// Normaliser: octave sum times 2^(k-1) over (2^k-1)*2^15, one quotient bit a stage.
// Uses widths from sfbm_pkg; instantiated by simplex_noise_fbm_core.
`default_nettype none
module sfbm_norm (
    input  wire logic                                 aclk,
    input  wire logic                                 en,
    input  wire logic signed [sfbm_pkg::ACC_W-1:0]    acc,
    input  wire logic [sfbm_pkg::CNT_W-1:0]           k,
    output logic signed [sfbm_pkg::OUT_W-1:0]         result
);
    localparam int NW = 60;
    localparam int QB = 17;

    logic [NW-1:0] rem_reg [QB+1];
    logic [30:0]   den_reg [QB+1];
    logic [QB-1:0] q_reg   [QB+1];
    logic          neg_reg [QB+1], sat_reg [QB+1], zero_reg [QB+1];
    logic signed [sfbm_pkg::OUT_W-1:0] result_reg;

    logic [NW-1:0] mag, num;
    logic [30:0]   den;
    assign mag = acc[sfbm_pkg::ACC_W-1] ? NW'(-acc) : NW'(acc);
    assign num = (k == '0) ? '0 : mag << (k - 4'd1);
    assign den = 31'(((32'd1 << k) - 32'd1) << 15);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= num;
            den_reg[0]  <= den;
            q_reg[0]    <= '0;
            neg_reg[0]  <= acc[sfbm_pkg::ACC_W-1];
            zero_reg[0] <= (k == '0);
            sat_reg[0]  <= num >= (NW'(den) << QB);
            for (int i = 1; i <= QB; i++) begin
                den_reg[i]  <= den_reg[i-1];
                neg_reg[i]  <= neg_reg[i-1];
                zero_reg[i] <= zero_reg[i-1];
                sat_reg[i]  <= sat_reg[i-1];
                if (rem_reg[i-1] >= (NW'(den_reg[i-1]) << (QB - i))) begin
                    rem_reg[i] <= rem_reg[i-1] - (NW'(den_reg[i-1]) << (QB - i));
                    q_reg[i]   <= q_reg[i-1] | (QB'(1) << (QB - i));
                end else begin
                    rem_reg[i] <= rem_reg[i-1];
                    q_reg[i]   <= q_reg[i-1];
                end
            end
            if (zero_reg[QB]) begin
                result_reg <= '0;
            end else if (neg_reg[QB]) begin
                result_reg <= (sat_reg[QB] || q_reg[QB] > 17'd32768) ? -16'sd32768
                              : 16'(-$signed({1'b0, q_reg[QB]}));
            end else begin
                result_reg <= (sat_reg[QB] || q_reg[QB] > 17'd32767) ? 16'sd32767
                              : 16'(q_reg[QB]);
            end
        end
    end

    assign result = result_reg;
endmodule
`default_nettype wire

@@ sim/tb_simplex_noise_fbm_core.sv @@
// Self-checking testbench for simplex_noise_fbm_core: directed table, then random points
// over several register settings, checked against a fixed-point fBm predictor.
// Depends on sfbm_pkg and simplex_noise_fbm_core only.
`timescale 1ns / 100ps
module tb_simplex_noise_fbm_core;

    localparam int  PIPE_LAT   = 31;
    localparam int  DRAIN_WAIT = PIPE_LAT + 10;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  RAND_POINTS = 800;
    localparam longint F2 = 23988;
    localparam longint G2 = 13849;

    typedef struct {
        logic [23:0] freq;
        logic [3:0]  octaves;
        logic [31:0] x;
        logic [31:0] z;
        bit          known;
        logic [15:0] value;
    } point_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [31:0] point_x, [63:32] point_z
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [15:0] noise_value
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [sfbm_pkg::CFG_W-1:0] cfg_wdata;

    logic [23:0] freq_model;
    logic [3:0]  octaves_model;
    logic [15:0] noise_pending[$];
    int          errors;
    int          cycles;
    bit          burst_on;
    int          burst_left;
    logic [15:0] stall_pattern;
    point_row_t  rows[$];

    simplex_noise_fbm_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint corner_term(logic [31:0] ci, logic [31:0] cj,
                                           longint x, longint y);
        longint t, t30, t2, t4, gx, gy;
        logic [31:0] h;
        t = (longint'(1) <<< 31) - x * x - y * y;
        if (t <= 0) return 0;
        t30 = t >>> 2;
        t2  = (t30 * t30) >>> 30;
        t4  = (t2 * t2) >>> 30;
        h = ci * sfbm_pkg::HASH_MX + cj * sfbm_pkg::HASH_MY;
        h = h ^ (h >> 13);
        h = h * sfbm_pkg::HASH_MIX;
        h = h ^ (h >> 16);
        case (h[2:0])
            3'd0: begin gx = 1;  gy = 1;  end
            3'd1: begin gx = -1; gy = 1;  end
            3'd2: begin gx = 1;  gy = -1; end
            3'd3: begin gx = -1; gy = -1; end
            3'd4: begin gx = 1;  gy = 0;  end
            3'd5: begin gx = -1; gy = 0;  end
            3'd6: begin gx = 0;  gy = 1;  end
            default: begin gx = 0; gy = -1; end
        endcase
        return t4 * (gx * x + gy * y);
    endfunction

    // Simplex value in Q.30 at a Q.16 point.
    function automatic longint simplex_at(longint cx, longint cz);
        longint s, bx, bz, xf, zf, u, x0, y0, i1, j1, sum;
        logic [31:0] ci, cj;
        s  = ((cx + cz) * F2) >>> 16;
        bx = cx + s;
        bz = cz + s;
        ci = 32'(bx >>> 16);
        cj = 32'(bz >>> 16);
        xf = bx & 64'hFFFF;
        zf = bz & 64'hFFFF;
        u  = ((xf + zf) * G2) >>> 16;
        x0 = xf - u;
        y0 = zf - u;
        i1 = (xf > zf) ? 1 : 0;
        j1 = 1 - i1;
        sum = corner_term(ci, cj, x0, y0)
            + corner_term(ci + 32'(i1), cj + 32'(j1), x0 - i1 * 65536 + G2,
                          y0 - j1 * 65536 + G2)
            + corner_term(ci + 32'd1, cj + 32'd1, x0 - 65536 + 2 * G2,
                          y0 - 65536 + 2 * G2);
        return (sum * 70) >>> 16;
    endfunction

    function automatic logic [15:0] fbm_noise(logic [31:0] x, logic [31:0] z);
        longint px, pz, acc, res;
        int k;
        px = longint'(int'(x)) * longint'(freq_model);
        pz = longint'(int'(z)) * longint'(freq_model);
        k = (octaves_model > sfbm_pkg::DEF_MAX_OCT) ? sfbm_pkg::DEF_MAX_OCT
                                                    : int'(octaves_model);
        if (k == 0) return 16'd0;
        acc = 0;
        for (int o = 0; o < k; o++)
            acc += simplex_at(px >>> (24 - o), pz >>> (24 - o)) >>> o;
        res = (acc * (longint'(1) <<< (k - 1))) / (((longint'(1) <<< k) - 1) * 32768);
        if (res > 32767) res = 32767;
        if (res < -32768) res = -32768;
        return res[15:0];
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("MISMATCH %s: got %0d, expected %0d at cycle %0d",
                 what, $signed(got), $signed(want), cycles);
        errors++;
    endtask

    // Registers change only once the pipeline has emptied.
    task automatic write_reg(logic idx, logic [sfbm_pkg::CFG_W-1:0] val);
        wait (noise_pending.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == sfbm_pkg::CFG_BASE_FREQ) freq_model = val[23:0];
        else octaves_model = val[3:0];
    endtask

    task automatic set_config(logic [23:0] f, logic [3:0] k);
        if (f != freq_model) write_reg(sfbm_pkg::CFG_BASE_FREQ, sfbm_pkg::CFG_W'(f));
        if (k != octaves_model) write_reg(sfbm_pkg::CFG_OCT_COUNT, sfbm_pkg::CFG_W'(k));
    endtask

    // Sends one point; the sender holds tvalid across a burst and gaps between bursts.
    task automatic send_point(logic [31:0] x, logic [31:0] z, bit known, logic [15:0] value);
        logic [15:0] predicted;
        if (burst_left == 0) begin
            if (s_tvalid) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            burst_left = burst_on ? $urandom_range(1, 40) : 1;
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {z, x};
        do @(posedge aclk); while (!s_tready);
        predicted = fbm_noise(x, z);
        if (known && predicted != value)
            report_mismatch("predictor against table", predicted, value);
        noise_pending.push_back(known ? value : predicted);
    endtask

    task automatic pause_sender();
        if (s_tvalid) s_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 3))
            0: return 32'($urandom_range(0, 20 << 16)) - 32'(10 << 16);
            1: return $urandom;
            2: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
            default: return {$urandom_range(0, 1) == 1 ? 1'b1 : 1'b0, 31'($urandom)};
        endcase
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Output side: checks each result and stalls on its own changing pattern.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b1;
            stall_pattern <= 16'hFFFF;
        end else begin
            if (m_tvalid && m_tready) begin
                if (noise_pending.size() == 0)
                    report_mismatch("unexpected noise_value", m_tdata, 16'hx);
                else if (m_tdata !== noise_pending[0])
                    report_mismatch("noise_value", m_tdata, noise_pending.pop_front());
                else
                    void'(noise_pending.pop_front());
            end
            if ($urandom_range(0, 63) == 0)
                stall_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
            else
                stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
            m_tready <= stall_pattern[0];
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = sfbm_pkg::CFG_BASE_FREQ;
        cfg_wdata = '0;
        m_tready  = 1'b1;
        errors    = 0;
        cycles    = 0;
        burst_on  = 1'b0;
        burst_left = 0;
        freq_model = 24'd65536;
        octaves_model = 4'd4;

        // Directed points: reset settings, extremes of each field and register.
        rows.push_back('{24'd65536, 4'd4, 32'h0, 32'h0, 0, 0});
        rows.push_back('{24'd65536, 4'd4, 32'h7FFFFFFF, 32'h80000000, 0, 0});
        rows.push_back('{24'd65536, 4'd4, 32'h80000000, 32'h7FFFFFFF, 0, 0});
        rows.push_back('{24'd65536, 4'd4, 32'hFFFFFFFF, 32'h00000001, 0, 0});
        rows.push_back('{24'd65536, 4'd4, 32'h00018000, 32'hFFFE8000, 0, 0});
        // Zero octaves always gives zero.
        rows.push_back('{24'd65536, 4'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 16'd0});
        rows.push_back('{24'd65536, 4'd0, 32'h80000000, 32'h12345678, 1, 16'd0});
        rows.push_back('{24'd16777215, 4'd0, 32'hDEADBEEF, 32'h80000000, 1, 16'd0});
        rows.push_back('{24'd16777215, 4'd8, 32'h7FFFFFFF, 32'h80000000, 0, 0});
        rows.push_back('{24'd16777215, 4'd8, 32'h80000000, 32'h80000000, 0, 0});
        rows.push_back('{24'd16777215, 4'd8, 32'h00030000, 32'h00050000, 0, 0});
        // Counts above the maximum behave as the maximum.
        rows.push_back('{24'd16777215, 4'd15, 32'h00030000, 32'h00050000, 0, 0});
        rows.push_back('{24'd16777215, 4'd9, 32'hFFFF0000, 32'h7FFFFFFF, 0, 0});
        // Zero frequency samples the origin in every octave; then the smallest and a middle frequency.
        rows.push_back('{24'd0, 4'd8, 32'h7FFFFFFF, 32'h80000000, 0, 0});
        rows.push_back('{24'd0, 4'd1, 32'h12345678, 32'h9ABCDEF0, 0, 0});
        rows.push_back('{24'd1, 4'd1, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0});
        rows.push_back('{24'd1, 4'd1, 32'h80000000, 32'hFFFFFFFF, 0, 0});
        rows.push_back('{24'd8388608, 4'd2, 32'h00000000, 32'hFFFFFFFF, 0, 0});
        rows.push_back('{24'd8388608, 4'd2, 32'hAAAAAAAA, 32'h55555555, 0, 0});

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            if (rows[i].freq != freq_model || rows[i].octaves != octaves_model) begin
                pause_sender();
                set_config(rows[i].freq, rows[i].octaves);
            end
            send_point(rows[i].x, rows[i].z, rows[i].known, rows[i].value);
        end

        // Random phases over several settings; each change waits for the pipeline to empty.
        burst_on = 1'b1;
        for (int phase = 0; phase < 8; phase++) begin
            logic [23:0] f;
            logic [3:0]  k;
            case (phase)
                0: begin f = 24'd65536;    k = 4'd4; end
                1: begin f = 24'd16777215; k = 4'd8; end
                2: begin f = 24'd1;        k = 4'd1; end
                3: begin f = 24'd0;        k = 4'd3; end
                4: begin f = 24'd1048576;  k = 4'd12; end
                default: begin f = 24'($urandom); k = 4'($urandom_range(0, 15)); end
            endcase
            pause_sender();
            set_config(f, k);
            for (int n = 0; n < RAND_POINTS / 8; n++)
                send_point(random_coord(), random_coord(), 0, 0);
        end
        pause_sender();

        wait (noise_pending.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (noise_pending.size() != 0)
            report_mismatch("missing noise_value", 16'hx, noise_pending[0]);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
